// ----- rtl/quad_corner_picker_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the quadrilateral corner picker
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef QUAD_CORNER_PICKER_TOP_ASSERT_SVH
`define QUAD_CORNER_PICKER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QCP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qcp port check failed");

// The consequent must hold in the cycle after the antecedent.
`define QCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qcp port check failed");

`endif

// ----- rtl/qcp_pkg.sv -----
// ----------------------------------------------------------------------------
// qcp_pkg
// Register indexes, microcode format and microcode program of the corner picker.
// ----------------------------------------------------------------------------
package qcp_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FRAME_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_EUCLID_WEIGHT = 2'd2;

  // Index of the final corner of a run (bottom-right).
  localparam logic [1:0] CORNER_LAST = 2'd3;

  typedef logic [2:0] step_t;

  // Program labels.
  localparam step_t STEP_WAIT   = 3'd0;
  localparam step_t STEP_DIFF   = 3'd1;
  localparam step_t STEP_SQUARE = 3'd2;
  localparam step_t STEP_RADIC  = 3'd3;
  localparam step_t STEP_ROOT   = 3'd4;
  localparam step_t STEP_WEIGHT = 3'd5;
  localparam step_t STEP_UPDATE = 3'd6;
  localparam step_t STEP_EMIT   = 3'd7;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_INPUT,
    COND_ROOT_MORE,
    COND_NOT_LAST,
    COND_EMIT_MORE
  } jump_cond_t;

  typedef struct packed {
    logic       take_in;
    logic       ld_diff;
    logic       ld_square;
    logic       ld_radic;
    logic       root_step;
    logic       ld_wterm;
    logic       update;
    logic       emit;
    jump_cond_t cond;
    step_t      target;
  } ctrl_word_t;

  // Control store. When the jump condition is false the step counter simply
  // advances, wrapping from the emit step back to the wait step.
  function automatic ctrl_word_t qcp_ucode(input step_t s);
    ctrl_word_t cw;
    cw = '{take_in: 1'b0, ld_diff: 1'b0, ld_square: 1'b0, ld_radic: 1'b0,
           root_step: 1'b0, ld_wterm: 1'b0, update: 1'b0, emit: 1'b0,
           cond: COND_NEVER, target: STEP_WAIT};
    case (s)
      STEP_WAIT: begin
        cw.take_in = 1'b1;
        cw.cond    = COND_NO_INPUT;
        cw.target  = STEP_WAIT;
      end
      STEP_DIFF:   cw.ld_diff   = 1'b1;
      STEP_SQUARE: cw.ld_square = 1'b1;
      STEP_RADIC:  cw.ld_radic  = 1'b1;
      STEP_ROOT: begin
        cw.root_step = 1'b1;
        cw.cond      = COND_ROOT_MORE;
        cw.target    = STEP_ROOT;
      end
      STEP_WEIGHT: cw.ld_wterm = 1'b1;
      STEP_UPDATE: begin
        cw.update = 1'b1;
        cw.cond   = COND_NOT_LAST;
        cw.target = STEP_WAIT;
      end
      STEP_EMIT: begin
        cw.emit   = 1'b1;
        cw.cond   = COND_EMIT_MORE;
        cw.target = STEP_EMIT;
      end
      default: cw.target = STEP_WAIT;
    endcase
    return cw;
  endfunction

endpackage

// ----- rtl/qcp_ifs.sv -----
// ----------------------------------------------------------------------------
// Corner picker channel interfaces
// Valid/ready channels for contour points and for corner results.
// ----------------------------------------------------------------------------
interface qcp_in_if #(parameter int COORD_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic                  last_point;

  modport source(output valid, output point_x, output point_y, output last_point,
                 input ready);
  modport sink(input valid, input point_x, input point_y, input last_point,
               output ready);
endinterface

interface qcp_out_if #(parameter int COORD_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic [1:0]            corner_index;
  logic [COORD_BITS-1:0] corner_x;
  logic [COORD_BITS-1:0] corner_y;
  logic                  corner_found;
  logic                  last_corner;

  modport source(output valid, output corner_index, output corner_x, output corner_y,
                 output corner_found, output last_corner, input ready);
  modport sink(input valid, input corner_index, input corner_x, input corner_y,
               input corner_found, input last_corner, output ready);
endinterface

// ----- rtl/quad_corner_picker_top.sv -----
// ----------------------------------------------------------------------------
// quad_corner_picker_top
// Picks the four corner points of a quadrilateral contour.
// ----------------------------------------------------------------------------
// Contour points enter one item at a time on in_pt (valid/ready). Each point is
// sorted into a quadrant of the frame and scored against that quadrant's frame
// corner; every quadrant keeps its lowest score and the point that gave it.
// The item flagged last_point makes the block send four corner items on
// out_cr in order top-left, top-right, bottom-left, bottom-right, the fourth
// with last_corner set, and then forget the run.
// A point passes through four setup steps, one step per result bit of the integer
// square root (COORD_BITS + 5 steps), a weighting multiply and the compare/update
// step. The square root unit is iterated by the microcode. After the last point
// is updated the first corner item is loaded and the other three follow one per
// cycle while the receiver is ready. A stalled receiver holds the output register
// and the sequencer waits in its emit step; the next point is taken once the last
// corner is loaded. Configuration is to be written by the user through
// cfg_we/cfg_index/cfg_data while idle; the block itself does not enforce this.
// Synchronous reset restores default registers and clears all corner state.
// ----------------------------------------------------------------------------
module quad_corner_picker_top
  import qcp_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  qcp_in_if.sink                                      in_pt,
  qcp_out_if.source                                   out_cr,
  input  logic                                        cfg_we,
  input  logic [1:0]                                  cfg_index,
  input  logic [(COORD_BITS > 8 ? COORD_BITS : 8)-1:0] cfg_data
);

  localparam int CB        = COORD_BITS;
  localparam int SCORE_W   = CB + 6;
  localparam int RAD_W     = 2 * CB + 9;
  localparam int ROOT_W    = CB + 5;
  localparam int PROD_W    = ROOT_W + 8;
  localparam int ITER_LAST = CB + 4;
  localparam int CNT_W     = $clog2(CB + 5);

  // Configuration registers.
  logic [CB-1:0] fw_r;
  logic [CB-1:0] fh_r;
  logic [7:0]    wt_r;

  // Sequencer.
  step_t      step_r;
  step_t      step_nxt;
  ctrl_word_t cw;
  logic       jump;

  // Datapath.
  logic [CB-1:0]     x_r;
  logic [CB-1:0]     y_r;
  logic              last_r;
  logic [1:0]        q_r;
  logic [CB-1:0]     dx_r;
  logic [CB-1:0]     dy_r;
  logic [2*CB-1:0]   dx2_r;
  logic [2*CB-1:0]   dy2_r;
  logic [ROOT_W-1:0] man_r;
  logic [RAD_W-1:0]  rad_r;
  logic [RAD_W-1:0]  res_r;
  logic [RAD_W-1:0]  bit_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [ROOT_W-1:0] wterm_r;

  // Corner state.
  logic [SCORE_W-1:0] best_score_r [4];
  logic [CB-1:0]      best_x_r     [4];
  logic [CB-1:0]      best_y_r     [4];
  logic [3:0]         seen_r;
  logic [1:0]         k_r;

  // Output register.
  logic          out_valid_r;
  logic [1:0]    out_index_r;
  logic [CB-1:0] out_x_r;
  logic [CB-1:0] out_y_r;
  logic          out_found_r;
  logic          out_last_r;

  // Combinational helpers.
  logic               accept;
  logic               out_free;
  logic               emit_go;
  logic               right;
  logic               bottom;
  logic [CB-1:0]      dx_c;
  logic [CB-1:0]      dy_c;
  logic [RAD_W-1:0]   trial;
  logic [PROD_W-1:0]  prod;
  logic [SCORE_W-1:0] score;

  assign cw       = qcp_ucode(step_r);
  assign accept   = cw.take_in & in_pt.valid;
  assign out_free = !out_valid_r || out_cr.ready;
  assign emit_go  = cw.emit & out_free;

  assign in_pt.ready         = cw.take_in;
  assign out_cr.valid        = out_valid_r;
  assign out_cr.corner_index = out_index_r;
  assign out_cr.corner_x     = out_x_r;
  assign out_cr.corner_y     = out_y_r;
  assign out_cr.corner_found = out_found_r;
  assign out_cr.last_corner  = out_last_r;

  // Jump decision and next step.
  always_comb begin
    case (cw.cond)
      COND_NEVER:     jump = 1'b0;
      COND_NO_INPUT:  jump = !in_pt.valid;
      COND_ROOT_MORE: jump = (cnt_r != '0);
      COND_NOT_LAST:  jump = !last_r;
      COND_EMIT_MORE: jump = !out_free || (k_r != CORNER_LAST);
      default:        jump = 1'b0;
    endcase
    step_nxt = jump ? cw.target : step_t'(step_r + 3'd1);
  end

  // Quadrant split and distances to the quadrant's frame corner.
  always_comb begin
    right  = x_r >= {1'b0, fw_r[CB-1:1]};
    bottom = y_r >= {1'b0, fh_r[CB-1:1]};
    if (!right) begin
      dx_c = x_r;
    end else if (x_r >= fw_r) begin
      dx_c = x_r - fw_r;
    end else begin
      dx_c = fw_r - x_r;
    end
    if (!bottom) begin
      dy_c = y_r;
    end else if (y_r >= fh_r) begin
      dy_c = y_r - fh_r;
    end else begin
      dy_c = fh_r - y_r;
    end
  end

  // Root trial value, weighting product and clamped score.
  always_comb begin
    trial = res_r + bit_r;
    prod  = PROD_W'(wt_r) * PROD_W'(res_r[ROOT_W-1:0]);
    score = (man_r >= wterm_r) ? SCORE_W'(man_r - wterm_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= CB'(960);
      fh_r <= CB'(720);
      wt_r <= 8'd179;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:   fw_r <= cfg_data[CB-1:0];
        CFG_FRAME_HEIGHT:  fh_r <= cfg_data[CB-1:0];
        CFG_EUCLID_WEIGHT: wt_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

  // Datapath registers loaded by the control word.
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r    <= in_pt.point_x;
      y_r    <= in_pt.point_y;
      last_r <= in_pt.last_point;
    end
    if (cw.ld_diff) begin
      q_r  <= {bottom, right};
      dx_r <= dx_c;
      dy_r <= dy_c;
    end
    if (cw.ld_square) begin
      dx2_r <= (2*CB)'(dx_r) * (2*CB)'(dx_r);
      dy2_r <= (2*CB)'(dy_r) * (2*CB)'(dy_r);
      man_r <= {(CB+1)'(dx_r) + (CB+1)'(dy_r), 4'b0000};
    end
    if (cw.ld_radic) begin
      rad_r <= {(2*CB+1)'(dx2_r) + (2*CB+1)'(dy2_r), 8'h00};
      res_r <= '0;
      bit_r <= {1'b1, (RAD_W-1)'(0)};
      cnt_r <= CNT_W'(ITER_LAST);
    end
    // One result bit per step of the digit-by-digit square root.
    if (cw.root_step) begin
      if (rad_r >= trial) begin
        rad_r <= rad_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
      cnt_r <= cnt_r - CNT_W'(1);
    end
    if (cw.ld_wterm) begin
      wterm_r <= prod[PROD_W-1:8];
    end
  end

  // Per-quadrant best points and corner emission.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        best_score_r[i] <= '1;
        best_x_r[i]     <= '0;
        best_y_r[i]     <= '0;
      end
      seen_r <= '0;
      k_r    <= '0;
    end else if (cw.update) begin
      if (score < best_score_r[q_r]) begin
        best_score_r[q_r] <= score;
        best_x_r[q_r]     <= x_r;
        best_y_r[q_r]     <= y_r;
      end
      seen_r[q_r] <= 1'b1;
      k_r         <= '0;
    end else if (emit_go) begin
      k_r <= k_r + 2'd1;
      // The run is over once the last corner is loaded.
      if (k_r == CORNER_LAST) begin
        for (int i = 0; i < 4; i++) begin
          best_score_r[i] <= '1;
          best_x_r[i]     <= '0;
          best_y_r[i]     <= '0;
        end
        seen_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_cr.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_index_r <= k_r;
      out_x_r     <= best_x_r[k_r];
      out_y_r     <= best_y_r[k_r];
      out_found_r <= seen_r[k_r];
      out_last_r  <= (k_r == CORNER_LAST);
    end
  end

endmodule

// ----- rtl/qcp_checker.sv -----
// ----------------------------------------------------------------------------
// qcp_checker
// Port-level checks of the corner picker, bound to the top level.
// ----------------------------------------------------------------------------
`include "quad_corner_picker_top_assert.svh"

module qcp_checker
  import qcp_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [1:0]            out_corner_index,
  input logic [COORD_BITS-1:0] out_corner_x,
  input logic [COORD_BITS-1:0] out_corner_y,
  input logic                  out_corner_found,
  input logic                  out_last_corner
);

  // A stalled corner item keeps its contents.
  `QCP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_corner_index) && $stable(out_corner_x) && $stable(out_corner_y))

  // Only the bottom-right corner closes a run.
  `QCP_ASSERT_NOW(a_last_is_final, clk, rst_n, out_valid && out_last_corner, out_corner_index == CORNER_LAST)

  // Corners of one run come back to back in index order.
  `QCP_ASSERT_NEXT(a_corner_order, clk, rst_n, out_valid && out_ready && !out_last_corner, out_valid && (out_corner_index == $past(out_corner_index) + 2'd1))

  // An empty quadrant reports the origin.
  `QCP_ASSERT_NOW(a_empty_zero, clk, rst_n, out_valid && !out_corner_found, (out_corner_x == '0) && (out_corner_y == '0))

  // No new point is taken while a run is still being reported.
  `QCP_ASSERT_NOW(a_no_take_mid_run, clk, rst_n, in_valid && in_ready, !(out_valid && !out_last_corner))

endmodule

bind quad_corner_picker_top qcp_checker #(.COORD_BITS(COORD_BITS)) u_qcp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_pt.valid),
  .in_ready         (in_pt.ready),
  .out_valid        (out_cr.valid),
  .out_ready        (out_cr.ready),
  .out_corner_index (out_cr.corner_index),
  .out_corner_x     (out_cr.corner_x),
  .out_corner_y     (out_cr.corner_y),
  .out_corner_found (out_cr.corner_found),
  .out_last_corner  (out_cr.last_corner)
);
